[src/rpn4_pkg.sv]
// Shared types, operation codes and constants of the four-level RPN stack ALU.
package rpn4_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_PUSH = 3'd0;
  localparam op_t OP_ADD  = 3'd1;
  localparam op_t OP_SUB  = 3'd2;
  localparam op_t OP_MUL  = 3'd3;
  localparam op_t OP_DIV  = 3'd4;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic mul_load;
    logic div_init;
    logic div_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic x_zero;
    logic div_big;
    logic out_free;
  } sts_t;

endpackage

[src/rpn4_ctrl.sv]
// Sequencer of the RPN stack ALU: accepts a request, runs multiply or divide, commits.
module rpn4_ctrl
  import rpn4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  in_op,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Hold state and divide step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_MUL:  state_next = ST_MUL;
            OP_DIV:  state_next = ST_DIV_INIT;
            default: state_next = ST_COMMIT;
          endcase
        end
      end
      ST_MUL: state_next = ST_COMMIT;
      ST_DIV_INIT: begin
        cnt_next = CNT_W'(DIV_STEPS - 1);
        // zero divisor or a quotient beyond 32 bits needs no iterations
        if (sts.x_zero || sts.div_big) begin
          state_next = ST_COMMIT;
        end else begin
          state_next = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MUL:      cmd.mul_load = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV_RUN:  cmd.div_step = 1'b1;
      ST_COMMIT:   cmd.commit   = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/rpn4_dp.sv]
// Datapath of the RPN stack ALU: stack registers, multiplier, radix-2 divider, result register.
module rpn4_dp
  import rpn4_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  op_t                 in_op,
  input  logic [DATA_W-1:0]   in_operand,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4*DATA_W-1:0] out_data,
  output logic [1:0]          out_flags
);

  localparam int unsigned PROD_W = 2 * DATA_W;

  logic [DATA_W-1:0] stack_x, stack_y, stack_z, stack_t;
  logic [DATA_W-1:0] x_next, y_next, z_next, t_next;
  op_t               op;
  logic [DATA_W-1:0] operand;
  logic [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_full;
  logic [DATA_W-1:0] rem, quo, dvs;
  logic              div_neg, div_big;
  logic              dz_next, ovf_next;

  logic [DATA_W-1:0] abs_y, abs_x;
  logic              big_now;
  logic [DATA_W:0]   shifted, trial;
  logic [DATA_W:0]   sum;
  logic              mul_fits;
  logic [DATA_W-1:0] res;
  logic              res_ovf;

  // Magnitudes for the divider and the early overflow check
  assign abs_y   = stack_y[DATA_W-1] ? (~stack_y + 1'b1) : stack_y;
  assign abs_x   = stack_x[DATA_W-1] ? (~stack_x + 1'b1) : stack_x;
  assign big_now = {{FRAC_W{1'b0}}, abs_y[DATA_W-1:FRAC_W]} >= abs_x;

  assign sts.x_zero   = (stack_x == '0);
  assign sts.div_big  = big_now;
  assign sts.out_free = !out_valid || out_ready;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= in_op;
      operand <= in_operand;
    end
  end

  // Signed product of Y and X at full width
  assign prod_full = $signed(stack_y) * $signed(stack_x);

  // Register the full product of Y and X
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= prod_full;
    end
  end

  // One quotient bit a cycle: shift the remainder, subtract the divisor if it fits
  assign shifted = {rem, quo[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= {{FRAC_W{1'b0}}, abs_y[DATA_W-1:FRAC_W]};
      quo     <= {abs_y[FRAC_W-1:0], {FRAC_W{1'b0}}};
      dvs     <= abs_x;
      div_neg <= stack_y[DATA_W-1] ^ stack_x[DATA_W-1];
      div_big <= big_now;
    end else if (cmd.div_step) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Arithmetic result with saturation
  assign mul_fits = (&prod[PROD_W-1:DATA_W+FRAC_W-1]) || !(|prod[PROD_W-1:DATA_W+FRAC_W-1]);

  always_comb begin
    sum     = '0;
    res     = '0;
    res_ovf = 1'b0;
    case (op)
      OP_ADD, OP_SUB: begin
        if (op == OP_ADD) begin
          sum = {stack_y[DATA_W-1], stack_y} + {stack_x[DATA_W-1], stack_x};
        end else begin
          sum = {stack_y[DATA_W-1], stack_y} - {stack_x[DATA_W-1], stack_x};
        end
        if (sum[DATA_W] != sum[DATA_W-1]) begin
          res_ovf = 1'b1;
          res     = sum[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
          res = sum[DATA_W-1:0];
        end
      end
      OP_MUL: begin
        if (mul_fits) begin
          res = prod[DATA_W+FRAC_W-1:FRAC_W];
        end else begin
          res_ovf = 1'b1;
          res     = prod[PROD_W-1] ? Q_MIN : Q_MAX;
        end
      end
      OP_DIV: begin
        if (div_big) begin
          res_ovf = 1'b1;
          res     = div_neg ? Q_MIN : Q_MAX;
        end else if (!div_neg) begin
          if (quo[DATA_W-1]) begin
            res_ovf = 1'b1;
            res     = Q_MAX;
          end else begin
            res = quo;
          end
        end else begin
          if (quo > Q_MIN) begin
            res_ovf = 1'b1;
            res     = Q_MIN;
          end else begin
            res = ~quo + 1'b1;
          end
        end
      end
      default: begin
        res     = '0;
        res_ovf = 1'b0;
      end
    endcase
  end

  // New stack contents: lift on push, drop on an operation, hold otherwise
  always_comb begin
    x_next   = stack_x;
    y_next   = stack_y;
    z_next   = stack_z;
    t_next   = stack_t;
    dz_next  = 1'b0;
    ovf_next = 1'b0;
    case (op)
      OP_PUSH: begin
        x_next = operand;
        y_next = stack_x;
        z_next = stack_y;
        t_next = stack_z;
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        x_next   = res;
        y_next   = stack_z;
        z_next   = stack_t;
        ovf_next = res_ovf;
      end
      OP_DIV: begin
        if (stack_x == '0) begin
          dz_next = 1'b1;
        end else begin
          x_next   = res;
          y_next   = stack_z;
          z_next   = stack_t;
          ovf_next = res_ovf;
        end
      end
      default: dz_next = 1'b0;
    endcase
  end

  // Stack registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_x <= '0;
      stack_y <= '0;
      stack_z <= '0;
      stack_t <= '0;
    end else if (cmd.commit) begin
      stack_x <= x_next;
      stack_y <= y_next;
      stack_z <= z_next;
      stack_t <= t_next;
    end
  end

  // Result register: load on commit, release when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data  <= {t_next, z_next, y_next, x_next};
      out_flags <= {ovf_next, dz_next};
    end
  end

endmodule

[src/rpn_four_level_stack_alu.sv]
// Top level of the four-level RPN stack ALU in signed Q16.16.
//
// Input stream: s_axis_tuser carries the operation (push, add, subtract,
// multiply, divide), s_axis_tdata the Q16.16 operand used by a push.
// Output stream: one result per request with X, Y, Z, T in m_axis_tdata and
// the divide-by-zero and overflow flags in m_axis_tuser.
// One request is in work at a time; s_axis_tready is high only while the
// sequencer is idle.
// From acceptance to m_axis_tvalid: push, add, subtract and unused codes go
// straight to commit, multiply first registers the product, and divide runs
// a setup state plus 32 radix-2 quotient steps, or only the setup state when
// the divisor is zero or the quotient already exceeds 32 bits. Back-to-back
// requests are taken in the cycle after the previous commit.
// A result waits in the output register while m_axis_tready is low; the next
// request is accepted and computed meanwhile, and its commit waits until the
// output register frees.
// Reset (rst, synchronous) clears X, Y, Z, T to zero and empties the output.
module rpn_four_level_stack_alu
  import rpn4_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,   // [31:0] operand
  input  logic [OP_W-1:0]     s_axis_tuser,   // [2:0] operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [4*DATA_W-1:0] m_axis_tdata,   // [31:0] reg_x, [63:32] reg_y,
                                              // [95:64] reg_z, [127:96] reg_t
  output logic [1:0]          m_axis_tuser    // [0] divide_by_zero, [1] overflow
);

  cmd_t cmd;
  sts_t sts;

  rpn4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpn4_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_axis_tuser),
    .in_operand (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_flags  (m_axis_tuser)
  );

endmodule

[src/rpn4_checker.sv]
// Port-level checks of the RPN stack ALU and their binding to the top level.
module rpn4_checker
  import rpn4_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [4*DATA_W-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // One request at a time: no acceptance right after one
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // Divide by zero and saturation never come together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("both status flags set");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind rpn_four_level_stack_alu rpn4_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[verif/rpn_four_level_stack_alu_tb.sv]
// Self-checking testbench for the four-level RPN stack ALU: directed and random requests.
module rpn_four_level_stack_alu_tb
  import rpn4_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned PRESSURE_HOLD = 200;
  localparam int unsigned PRESSURE_AT   = 60;

  // Operation codes the block ignores
  localparam op_t OP_SPARE_FIRST = 3'd5;
  localparam op_t OP_SPARE_LAST  = 3'd7;

  localparam logic [DATA_W-1:0] Q_ONE = 1 << FRAC_W;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] t;
    logic              div_zero;
    logic              overflow;
  } stack_image_t;

  // Tracks the X/Y/Z/T stack and holds the stack images still to come out
  class rpn_stack_scoreboard;
    stack_image_t      stack;
    stack_image_t      pending[$];
    int unsigned       errors;
    int unsigned       results_checked;
    logic              sat_hit;

    function new();
      stack = '{default: '0};
      errors = 0;
      results_checked = 0;
    endfunction

    function logic [DATA_W-1:0] saturate_q16(longint v);
      if (v > SAT_HI) begin
        sat_hit = 1'b1;
        return Q_MAX;
      end
      if (v < SAT_LO) begin
        sat_hit = 1'b1;
        return Q_MIN;
      end
      return v[DATA_W-1:0];
    endfunction

    // Apply one accepted request to the stack and queue the image it yields
    function void note_request(op_t op, logic [DATA_W-1:0] operand);
      longint       ys;
      longint       xs;
      longint       r;
      logic         drop;
      stack_image_t nxt;
      ys = longint'($signed(stack.y));
      xs = longint'($signed(stack.x));
      r = 0;
      drop = 1'b0;
      sat_hit = 1'b0;
      nxt = stack;
      nxt.div_zero = 1'b0;
      nxt.overflow = 1'b0;
      case (op)
        OP_PUSH: begin
          nxt.t = stack.z;
          nxt.z = stack.y;
          nxt.y = stack.x;
          nxt.x = operand;
        end
        OP_ADD: begin
          r = ys + xs;
          drop = 1'b1;
        end
        OP_SUB: begin
          r = ys - xs;
          drop = 1'b1;
        end
        OP_MUL: begin
          // arithmetic shift of the full product rounds toward minus infinity
          r = (ys * xs) >>> FRAC_W;
          drop = 1'b1;
        end
        OP_DIV: begin
          if (xs == 0) begin
            nxt.div_zero = 1'b1;
          end else begin
            r = (ys * (longint'(1) << FRAC_W)) / xs;
            drop = 1'b1;
          end
        end
        default: ;
      endcase
      if (drop) begin
        nxt.x = saturate_q16(r);
        nxt.overflow = sat_hit;
        nxt.y = stack.z;
        nxt.z = stack.t;
      end
      stack = nxt;
      pending.push_back(nxt);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest queued image
    function void check_result(logic [4*DATA_W-1:0] data, logic [1:0] flags);
      stack_image_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h flags %b", $time, data, flags);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("reg_x", want.x, data[DATA_W-1:0]);
      compare_field("reg_y", want.y, data[2*DATA_W-1:DATA_W]);
      compare_field("reg_z", want.z, data[3*DATA_W-1:2*DATA_W]);
      compare_field("reg_t", want.t, data[4*DATA_W-1:3*DATA_W]);
      compare_field("divide_by_zero", DATA_W'(want.div_zero), DATA_W'(flags[0]));
      compare_field("overflow", DATA_W'(want.overflow), DATA_W'(flags[1]));
      results_checked++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata = '0;    // [31:0] operand
  logic [OP_W-1:0]     s_axis_tuser = OP_PUSH; // [2:0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [4*DATA_W-1:0] m_axis_tdata;         // [31:0] x, [63:32] y, [95:64] z, [127:96] t
  logic [1:0]          m_axis_tuser;         // [0] divide_by_zero, [1] overflow

  rpn_stack_scoreboard sb = new();
  logic                tx_quiet = 1'b0;
  int unsigned         idle_cycles = 0;

  rpn_four_level_stack_alu uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic op_t pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return OP_PUSH;
    if (r < 55) return OP_ADD;
    if (r < 70) return OP_SUB;
    if (r < 83) return OP_MUL;
    if (r < 97) return OP_DIV;
    return op_t'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
  endfunction

  // Bias operands toward limits, zero and small magnitudes
  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = '0;
      3: v = $urandom_range(1) ? Q_ONE : -Q_ONE;
      4, 5, 6: begin
        v = $urandom_range(32'h000F_FFFF);
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(op_t op, logic [DATA_W-1:0] operand);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= operand;
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(op, operand);
  endtask

  // Send a request, then idle for a random gap unless in a quiet stretch
  task automatic issue(op_t op, logic [DATA_W-1:0] operand);
    int unsigned gap;
    send_request(op, operand);
    gap = tx_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // positive overflow on add, arithmetic operand ignored
    issue(OP_PUSH, Q_MAX);
    issue(OP_PUSH, Q_MAX);
    issue(OP_ADD, 32'hFFFF_FFFF);
    // negative overflow on subtract
    issue(OP_PUSH, Q_MIN);
    issue(OP_PUSH, Q_ONE);
    issue(OP_SUB, Q_MAX);
    // divide by zero leaves the stack alone
    issue(OP_PUSH, '0);
    issue(OP_DIV, '0);
    // most negative over minus one saturates
    issue(OP_PUSH, Q_MIN);
    issue(OP_PUSH, -Q_ONE);
    issue(OP_DIV, '0);
    // negative product rounds down
    issue(OP_PUSH, 32'hFFFF_FFFF);
    issue(OP_PUSH, 32'h0000_8000);
    issue(OP_MUL, '0);
    // product overflow toward the negative limit
    issue(OP_PUSH, Q_MAX);
    issue(OP_PUSH, Q_MIN);
    issue(OP_MUL, '0);
    // exact quotient 7 / 2
    issue(OP_PUSH, 32'h0007_0000);
    issue(OP_PUSH, 32'h0002_0000);
    issue(OP_DIV, '0);
    // unused codes change nothing
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
      issue(op_t'(c), Q_MAX);
    end

    // random RPN traffic, alternating quiet and gappy stretches
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) tx_quiet = ($urandom_range(2) == 0);
      issue(pick_op(), pick_operand());
    end
    s_axis_tvalid <= 1'b0;

    // drain everything outstanding
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("rpn_four_level_stack_alu regression: pass");
    end else begin
      $display("rpn_four_level_stack_alu regression: fail");
    end
    $finish;
  end

  // Result receiver: random stalls, quiet windows, one long hold-off
  initial begin : receiver
    int unsigned stall_left;
    int unsigned window;
    bit          held;
    bit          rx_quiet;
    stall_left = 0;
    window = 0;
    held = 1'b0;
    rx_quiet = 1'b0;
    forever begin
      @(posedge clk);
      window++;
      if (window % 64 == 0) rx_quiet = ($urandom_range(3) == 0);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (!held && sb.results_checked >= PRESSURE_AT) begin
        // hold off long enough for the block to back up its input
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = rx_quiet ? 0 : pick_gap();
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
      $display("rpn_four_level_stack_alu regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
